### hdl/krt_pkg.sv
`timescale 1ns / 1ps
// krt_pkg: shared constants, codes and controller/datapath command types
// for the keyed record table. No dependencies.
package krt_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [7:0]  FREE_DEV      = 8'hFF;
  localparam logic [23:0] EMPTY_KEY     = 24'hFF_FFFF;
  localparam logic [63:0] EMPTY_PAYLOAD = 64'h0000_0010_00FF_FFFF;

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_DEL  = 3'd1;
  localparam logic [2:0] MODE_GET  = 3'd2;
  localparam logic [2:0] MODE_SET  = 3'd3;
  localparam logic [2:0] MODE_READ = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic             latch_in;
    logic             scan_init;
    logic             rd_en;
    logic             rd_at_index;
    logic [IDX_W-1:0] rd_addr;
    logic             cmp_en;
    logic [IDX_W-1:0] cmp_addr;
    logic             cap_hit;
    logic             wr_en;
    logic             load_out;
  } krt_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       idx_ok;
  } krt_sts_t;

endpackage

### hdl/krt_datapath.sv
`timescale 1ns / 1ps
// krt_datapath: slot memories, valid bits, scan compare/trackers and result registers.
// Depends on krt_pkg.
module krt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  krt_pkg::krt_cmd_t   cmd,
  output krt_pkg::krt_sts_t   sts,
  input  logic [2:0]          in_mode,
  input  logic [7:0]          in_channel,
  input  logic [7:0]          in_dev_id,
  input  logic [7:0]          in_inst_id,
  input  logic [63:0]         in_payload,
  input  logic [7:0]          in_index,
  output logic [1:0]          out_status,
  output logic [7:0]          out_slot,
  output logic [7:0]          out_rec_channel,
  output logic [7:0]          out_rec_dev_id,
  output logic [7:0]          out_rec_inst_id,
  output logic [63:0]         out_rec_payload,
  output logic [7:0]          out_cleared_count
);

  localparam int IW = krt_pkg::IDX_W;

  logic [23:0]   key_mem [krt_pkg::ENTRIES];
  logic [63:0]   pay_mem [krt_pkg::ENTRIES];
  logic [krt_pkg::ENTRIES-1:0] vld_r;

  logic [2:0]    mode_r;
  logic [23:0]   key_r;
  logic [63:0]   pay_r;
  logic [7:0]    index_r;

  logic [23:0]   rd_key_r;
  logic [63:0]   rd_pay_r;
  logic          rd_vld_r;

  logic          match_found_r;
  logic [IW-1:0] match_idx_r;
  logic          free_found_r;
  logic [IW-1:0] free_idx_r;
  logic [7:0]    clr_cnt_r;
  logic [23:0]   hit_key_r;
  logic [63:0]   hit_pay_r;

  logic [1:0]    status_r;
  logic [7:0]    slot_r;
  logic [23:0]   rec_key_r;
  logic [63:0]   rec_pay_r;
  logic [7:0]    cleared_r;

  logic [1:0]    status_nxt;
  logic [7:0]    slot_nxt;
  logic [23:0]   rec_key_nxt;
  logic [63:0]   rec_pay_nxt;
  logic [7:0]    cleared_nxt;

  logic [23:0]   rd_key_eff;
  logic [63:0]   rd_pay_eff;
  logic [IW-1:0] rd_addr;
  logic          clr_mode;
  logic          clr_hit;
  logic          exact_hit;
  logic          free_hit;
  logic          use_match;
  logic          tgt_found;
  logic [IW-1:0] tgt_idx;
  logic          idx_ok;

  assign rd_key_eff = rd_vld_r ? rd_key_r : krt_pkg::EMPTY_KEY;
  assign rd_pay_eff = rd_vld_r ? rd_pay_r : krt_pkg::EMPTY_PAYLOAD;
  assign rd_addr    = cmd.rd_at_index ? index_r[IW-1:0] : cmd.rd_addr;
  assign idx_ok     = (index_r < 8'(krt_pkg::ENTRIES));

  assign clr_mode  = (mode_r == krt_pkg::MODE_DEL) ||
                     ((mode_r == krt_pkg::MODE_ADD) && (key_r[7:0] == 8'd0));
  assign clr_hit   = cmd.cmp_en && clr_mode && (rd_key_eff[23:8] == key_r[23:8]);
  assign exact_hit = cmd.cmp_en && (rd_key_eff == key_r);
  assign free_hit  = cmd.cmp_en && ((rd_key_eff[15:8] == krt_pkg::FREE_DEV) || clr_hit);

  assign use_match = (mode_r == krt_pkg::MODE_SET) && match_found_r;
  assign tgt_found = use_match || free_found_r;
  assign tgt_idx   = use_match ? match_idx_r : free_idx_r;

  assign sts.mode   = mode_r;
  assign sts.idx_ok = idx_ok;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode_r  <= in_mode;
      key_r   <= {in_channel, in_dev_id, in_inst_id};
      pay_r   <= in_payload;
      index_r <= in_index;
    end
  end

  // slot memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en && tgt_found) begin
      key_mem[tgt_idx] <= key_r;
      pay_mem[tgt_idx] <= pay_r;
    end
    if (cmd.rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_pay_r <= pay_mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (clr_hit) vld_r[cmd.cmp_addr] <= 1'b0;
      if (cmd.wr_en && tgt_found) vld_r[tgt_idx] <= 1'b1;
    end
  end

  // scan trackers
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      clr_cnt_r     <= 8'd0;
    end else begin
      if (exact_hit && !match_found_r) begin
        match_found_r <= 1'b1;
        match_idx_r   <= cmd.cmp_addr;
        hit_key_r     <= rd_key_eff;
        hit_pay_r     <= rd_pay_eff;
      end
      if (free_hit && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmd.cmp_addr;
      end
      if (clr_hit) clr_cnt_r <= clr_cnt_r + 8'd1;
      if (cmd.cap_hit) begin
        hit_key_r <= rd_key_eff;
        hit_pay_r <= rd_pay_eff;
      end
    end
  end

  always_comb begin
    status_nxt  = krt_pkg::ST_NOT_FOUND;
    slot_nxt    = 8'd0;
    rec_key_nxt = 24'd0;
    rec_pay_nxt = 64'd0;
    cleared_nxt = 8'd0;
    unique case (mode_r) inside
      krt_pkg::MODE_ADD, krt_pkg::MODE_SET: begin
        if (mode_r == krt_pkg::MODE_ADD) cleared_nxt = clr_cnt_r;
        if (tgt_found) begin
          status_nxt  = krt_pkg::ST_OK;
          slot_nxt    = 8'(tgt_idx);
          rec_key_nxt = key_r;
          rec_pay_nxt = pay_r;
        end else begin
          status_nxt = krt_pkg::ST_FULL;
        end
      end
      krt_pkg::MODE_DEL: begin
        status_nxt  = krt_pkg::ST_OK;
        cleared_nxt = clr_cnt_r;
      end
      krt_pkg::MODE_GET: begin
        if (match_found_r) begin
          status_nxt  = krt_pkg::ST_OK;
          slot_nxt    = 8'(match_idx_r);
          rec_key_nxt = hit_key_r;
          rec_pay_nxt = hit_pay_r;
        end
      end
      krt_pkg::MODE_READ: begin
        if (idx_ok) begin
          status_nxt  = krt_pkg::ST_OK;
          slot_nxt    = index_r;
          rec_key_nxt = hit_key_r;
          rec_pay_nxt = hit_pay_r;
        end else begin
          status_nxt = krt_pkg::ST_RANGE;
        end
      end
      default: status_nxt = krt_pkg::ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r  <= status_nxt;
      slot_r    <= slot_nxt;
      rec_key_r <= rec_key_nxt;
      rec_pay_r <= rec_pay_nxt;
      cleared_r <= cleared_nxt;
    end
  end

  assign out_status        = status_r;
  assign out_slot          = slot_r;
  assign out_rec_channel   = rec_key_r[23:16];
  assign out_rec_dev_id    = rec_key_r[15:8];
  assign out_rec_inst_id   = rec_key_r[7:0];
  assign out_rec_payload   = rec_pay_r;
  assign out_cleared_count = cleared_r;

endmodule

### hdl/krt_ctrl.sv
`timescale 1ns / 1ps
// krt_ctrl: sequencer for the keyed record table (decode, slot scan, write-back,
// result handshake). Depends on krt_pkg.
module krt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  krt_pkg::krt_sts_t sts,
  output krt_pkg::krt_cmd_t cmd
);

  localparam int IW = krt_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_DRAIN, S_WRITE, S_RDSLOT, S_RDWAIT, S_FIN
  } state_t;

  state_t        state_r;
  logic [IW-1:0] cnt_r;
  logic          cmp_en_r;
  logic [IW-1:0] cmp_addr_r;
  logic          out_valid_r;
  logic          out_free;
  logic          scan_last;

  assign out_free  = !out_valid_r || out_ready;
  assign scan_last = (cnt_r == IW'(krt_pkg::ENTRIES - 1));
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd             = '0;
    cmd.latch_in    = (state_r == S_IDLE) && in_valid;
    cmd.scan_init   = (state_r == S_DECODE);
    cmd.rd_en       = (state_r == S_SCAN) || (state_r == S_RDSLOT);
    cmd.rd_at_index = (state_r == S_RDSLOT);
    cmd.rd_addr     = cnt_r;
    cmd.cmp_en      = cmp_en_r;
    cmd.cmp_addr    = cmp_addr_r;
    cmd.cap_hit     = (state_r == S_RDWAIT);
    cmd.wr_en       = (state_r == S_WRITE);
    cmd.load_out    = (state_r == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cmp_en_r    <= 1'b0;
      cmp_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_en_r   <= (state_r == S_SCAN);
      cmp_addr_r <= cnt_r;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_DECODE;
        end
        S_DECODE: begin
          cnt_r <= '0;
          unique case (sts.mode) inside
            krt_pkg::MODE_ADD, krt_pkg::MODE_DEL,
            krt_pkg::MODE_GET, krt_pkg::MODE_SET: state_r <= S_SCAN;
            krt_pkg::MODE_READ: state_r <= sts.idx_ok ? S_RDSLOT : S_FIN;
            default: state_r <= S_FIN;
          endcase
        end
        S_SCAN: begin
          if (scan_last) state_r <= S_DRAIN;
          else cnt_r <= cnt_r + IW'(1);
        end
        S_DRAIN: begin
          if (sts.mode == krt_pkg::MODE_ADD || sts.mode == krt_pkg::MODE_SET) begin
            state_r <= S_WRITE;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_WRITE:  state_r <= S_FIN;
        S_RDSLOT: state_r <= S_RDWAIT;
        S_RDWAIT: state_r <= S_FIN;
        S_FIN: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/keyed_record_table.sv
`timescale 1ns / 1ps
// keyed_record_table: keyed slot table, one request in, one result out.
// Steps from acceptance to result valid: decode, a scan of one slot per cycle, drain,
// write-back for add/set, load; read slot goes decode, slot read, wait, load; an unknown
// mode or an out-of-range index goes from decode straight to load. One request in
// flight; the next is accepted after the result loads, a waiting result stalls.
// Reset: valid bits clear synchronously, so every slot reads free right after reset.
module keyed_record_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_channel,
  input  logic [7:0]  in_dev_id,
  input  logic [7:0]  in_inst_id,
  input  logic [63:0] in_payload,
  input  logic [7:0]  in_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_slot,
  output logic [7:0]  out_rec_channel,
  output logic [7:0]  out_rec_dev_id,
  output logic [7:0]  out_rec_inst_id,
  output logic [63:0] out_rec_payload,
  output logic [7:0]  out_cleared_count
);

  krt_pkg::krt_cmd_t cmd;
  krt_pkg::krt_sts_t sts;

  krt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  krt_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_channel        (in_channel),
    .in_dev_id         (in_dev_id),
    .in_inst_id        (in_inst_id),
    .in_payload        (in_payload),
    .in_index          (in_index),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_rec_channel   (out_rec_channel),
    .out_rec_dev_id    (out_rec_dev_id),
    .out_rec_inst_id   (out_rec_inst_id),
    .out_rec_payload   (out_rec_payload),
    .out_cleared_count (out_cleared_count)
  );

endmodule

### test/keyed_record_table_test.sv
`timescale 1ns / 1ps
// keyed_record_table_test: self-checking bench for keyed_record_table; a directed
// table then ~700 random requests, each checked against a given or shadow result.
// Depends on krt_pkg and the keyed_record_table RTL.
module keyed_record_table_test;

  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam int RANDOM_ITEMS = 700;

  typedef struct {
    logic [2:0]  mode;
    logic [7:0]  channel;
    logic [7:0]  dev_id;
    logic [7:0]  inst_id;
    logic [63:0] payload;
    logic [7:0]  index;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [7:0]  channel;
    logic [7:0]  dev_id;
    logic [7:0]  inst_id;
    logic [63:0] payload;
    logic [7:0]  cleared;
  } table_result_t;

  typedef struct {
    request_t      req;
    bit            typed;
    table_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic [7:0]  in_channel;
  logic [7:0]  in_dev_id;
  logic [7:0]  in_inst_id;
  logic [63:0] in_payload;
  logic [7:0]  in_index;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_slot;
  logic [7:0]  out_rec_channel;
  logic [7:0]  out_rec_dev_id;
  logic [7:0]  out_rec_inst_id;
  logic [63:0] out_rec_payload;
  logic [7:0]  out_cleared_count;

  logic [23:0]   shadow_key [krt_pkg::ENTRIES];
  logic [63:0]   shadow_payload [krt_pkg::ENTRIES];
  table_result_t pending_results [$];
  stim_row_t     directed [$];
  int            mismatch_count = 0;
  bit            no_idle = 0;

  keyed_record_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_channel(in_channel), .in_dev_id(in_dev_id),
    .in_inst_id(in_inst_id), .in_payload(in_payload), .in_index(in_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_slot(out_slot),
    .out_rec_channel(out_rec_channel), .out_rec_dev_id(out_rec_dev_id),
    .out_rec_inst_id(out_rec_inst_id), .out_rec_payload(out_rec_payload),
    .out_cleared_count(out_cleared_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic table_result_t make_result(logic [1:0] status, int slot,
                                                logic [23:0] key, logic [63:0] payload,
                                                int cleared);
    table_result_t r;
    r.status  = status;
    r.slot    = 8'(slot);
    r.channel = key[23:16];
    r.dev_id  = key[15:8];
    r.inst_id = key[7:0];
    r.payload = payload;
    r.cleared = 8'(cleared);
    return r;
  endfunction

  function automatic request_t make_request(logic [2:0] mode, logic [7:0] channel,
                                            logic [7:0] dev_id, logic [7:0] inst_id,
                                            logic [63:0] payload, logic [7:0] index);
    request_t r;
    r.mode    = mode;
    r.channel = channel;
    r.dev_id  = dev_id;
    r.inst_id = inst_id;
    r.payload = payload;
    r.index   = index;
    return r;
  endfunction

  function automatic int clear_device(logic [23:0] key);
    int n;
    n = 0;
    for (int i = 0; i < krt_pkg::ENTRIES; i++) begin
      if (shadow_key[i][23:8] == key[23:8]) begin
        shadow_key[i]     = krt_pkg::EMPTY_KEY;
        shadow_payload[i] = krt_pkg::EMPTY_PAYLOAD;
        n++;
      end
    end
    return n;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < krt_pkg::ENTRIES; i++)
      if (shadow_key[i][15:8] == krt_pkg::FREE_DEV) return i;
    return krt_pkg::ENTRIES;
  endfunction

  function automatic int first_key_match(logic [23:0] key);
    for (int i = 0; i < krt_pkg::ENTRIES; i++)
      if (shadow_key[i] == key) return i;
    return krt_pkg::ENTRIES;
  endfunction

  function automatic table_result_t predict_table(request_t r);
    logic [23:0]   key;
    int            hit;
    int            cleared;
    table_result_t res;
    key     = {r.channel, r.dev_id, r.inst_id};
    cleared = 0;
    res     = make_result(krt_pkg::ST_NOT_FOUND, 0, 24'h0, 64'h0, 0);
    case (r.mode)
      krt_pkg::MODE_ADD: begin
        if (r.inst_id == 8'h00) cleared = clear_device(key);
        hit = first_free_slot();
        if (hit == krt_pkg::ENTRIES) begin
          res = make_result(krt_pkg::ST_FULL, 0, 24'h0, 64'h0, cleared);
        end else begin
          shadow_key[hit]     = key;
          shadow_payload[hit] = r.payload;
          res = make_result(krt_pkg::ST_OK, hit, key, r.payload, cleared);
        end
      end
      krt_pkg::MODE_DEL: begin
        cleared = clear_device(key);
        res = make_result(krt_pkg::ST_OK, 0, 24'h0, 64'h0, cleared);
      end
      krt_pkg::MODE_GET: begin
        hit = first_key_match(key);
        if (hit != krt_pkg::ENTRIES)
          res = make_result(krt_pkg::ST_OK, hit, shadow_key[hit], shadow_payload[hit], 0);
      end
      krt_pkg::MODE_SET: begin
        hit = first_key_match(key);
        if (hit == krt_pkg::ENTRIES) hit = first_free_slot();
        if (hit == krt_pkg::ENTRIES) begin
          res = make_result(krt_pkg::ST_FULL, 0, 24'h0, 64'h0, 0);
        end else begin
          shadow_key[hit]     = key;
          shadow_payload[hit] = r.payload;
          res = make_result(krt_pkg::ST_OK, hit, key, r.payload, 0);
        end
      end
      krt_pkg::MODE_READ: begin
        if (r.index < krt_pkg::ENTRIES)
          res = make_result(krt_pkg::ST_OK, r.index, shadow_key[r.index],
                            shadow_payload[r.index], 0);
        else
          res = make_result(krt_pkg::ST_RANGE, 0, 24'h0, 64'h0, 0);
      end
      default: res = make_result(krt_pkg::ST_NOT_FOUND, 0, 24'h0, 64'h0, 0);
    endcase
    return res;
  endfunction

  // mostly a small pool of values so keys collide, now and then anything
  function automatic logic [7:0] pick_key_part(logic [7:0] a, logic [7:0] b,
                                               logic [7:0] c, logic [7:0] d);
    case ($urandom_range(9))
      0, 1: return a;
      2, 3: return b;
      4, 5: return c;
      6, 7: return d;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic request_t random_request(int n);
    request_t r;
    int       k;
    r.payload = {$urandom, $urandom};
    r.index   = ($urandom_range(9) < 7) ? 8'($urandom_range(krt_pkg::ENTRIES - 1))
                                        : 8'($urandom);
    if (n >= 250 && n < 330) begin
      // distinct keys until the table runs full
      r.mode    = $urandom_range(1) ? krt_pkg::MODE_ADD : krt_pkg::MODE_SET;
      r.channel = 8'(n);
      r.dev_id  = 8'($urandom_range(254));
      r.inst_id = 8'($urandom_range(1, 255));
    end else begin
      k = $urandom_range(99);
      if (k < 25)      r.mode = krt_pkg::MODE_ADD;
      else if (k < 35) r.mode = krt_pkg::MODE_DEL;
      else if (k < 55) r.mode = krt_pkg::MODE_GET;
      else if (k < 75) r.mode = krt_pkg::MODE_SET;
      else if (k < 95) r.mode = krt_pkg::MODE_READ;
      else             r.mode = 3'($urandom_range(MODE_RSVD5, MODE_RSVD7));
      r.channel = pick_key_part(8'h00, 8'h01, 8'h02, 8'hFF);
      r.dev_id  = pick_key_part(8'h00, 8'h03, 8'hFE, 8'hFF);
      r.inst_id = pick_key_part(8'h00, 8'h01, 8'h02, 8'hFF);
    end
    return r;
  endfunction

  task automatic send_request(request_t r, bit typed, table_result_t want);
    table_result_t predicted;
    while (!no_idle && $urandom_range(99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_mode    = r.mode;
    in_channel = r.channel;
    in_dev_id  = r.dev_id;
    in_inst_id = r.inst_id;
    in_payload = r.payload;
    in_index   = r.index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_table(r);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) out_ready = no_idle || ($urandom_range(99) >= 12);

  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, status %0h slot %0h",
                 $time, out_status, out_slot);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("slot", want.slot, out_slot);
        check_field("rec_channel", want.channel, out_rec_channel);
        check_field("rec_dev_id", want.dev_id, out_rec_dev_id);
        check_field("rec_inst_id", want.inst_id, out_rec_inst_id);
        check_field("rec_payload", want.payload, out_rec_payload);
        check_field("cleared_count", want.cleared, out_cleared_count);
      end
    end
  end

  function automatic void add_row(request_t r, bit typed, table_result_t want);
    stim_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = want;
    directed.push_back(row);
  endfunction

  initial begin
    table_result_t none;
    none = make_result(krt_pkg::ST_NOT_FOUND, 0, 24'h0, 64'h0, 0);
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_mode    = krt_pkg::MODE_ADD;
    in_channel = 8'h00;
    in_dev_id  = 8'h00;
    in_inst_id = 8'h00;
    in_payload = 64'h0;
    in_index   = 8'h00;
    out_ready  = 1'b0;
    for (int i = 0; i < krt_pkg::ENTRIES; i++) begin
      shadow_key[i]     = krt_pkg::EMPTY_KEY;
      shadow_payload[i] = krt_pkg::EMPTY_PAYLOAD;
    end

    // empty table, range errors, reserved modes
    add_row(make_request(krt_pkg::MODE_GET, 8'h00, 8'h00, 8'h00, 64'h0, 8'h00), 1, none);
    add_row(make_request(krt_pkg::MODE_READ, 8'h00, 8'h00, 8'h00, 64'h0, 8'd0), 1,
            make_result(krt_pkg::ST_OK, 0, krt_pkg::EMPTY_KEY, krt_pkg::EMPTY_PAYLOAD, 0));
    add_row(make_request(krt_pkg::MODE_READ, 8'h00, 8'h00, 8'h00, 64'h0,
                         8'(krt_pkg::ENTRIES - 1)), 1,
            make_result(krt_pkg::ST_OK, krt_pkg::ENTRIES - 1, krt_pkg::EMPTY_KEY,
                        krt_pkg::EMPTY_PAYLOAD, 0));
    add_row(make_request(krt_pkg::MODE_READ, 8'h00, 8'h00, 8'h00, 64'h0,
                         8'(krt_pkg::ENTRIES)), 1,
            make_result(krt_pkg::ST_RANGE, 0, 24'h0, 64'h0, 0));
    add_row(make_request(krt_pkg::MODE_READ, 8'hFF, 8'hFF, 8'hFF, '1, 8'hFF), 1,
            make_result(krt_pkg::ST_RANGE, 0, 24'h0, 64'h0, 0));
    add_row(make_request(MODE_RSVD5, 8'h00, 8'h00, 8'h00, 64'h0, 8'h00), 1, none);
    add_row(make_request(MODE_RSVD6, 8'hFF, 8'hFF, 8'hFF, '1, 8'hFF), 1, none);
    add_row(make_request(MODE_RSVD7, 8'h5A, 8'hA5, 8'h00, 64'h1, 8'h01), 1, none);
    add_row(make_request(krt_pkg::MODE_DEL, 8'h12, 8'h34, 8'h56, 64'h0, 8'h00), 1,
            make_result(krt_pkg::ST_OK, 0, 24'h0, 64'h0, 0));
    // adds, lookups, upserts, wildcard add
    add_row(make_request(krt_pkg::MODE_ADD, 8'h00, 8'h00, 8'h01, 64'h0, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_ADD, 8'hFF, 8'hFE, 8'hFF, '1, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_ADD, 8'h00, 8'h00, 8'h02,
                         64'hDEAD_BEEF_0123_4567, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_GET, 8'h00, 8'h00, 8'h02, 64'h0, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_SET, 8'h00, 8'h00, 8'h02,
                         64'h8000_0000_0000_0001, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_SET, 8'h07, 8'h09, 8'h03,
                         64'h0F0F_F0F0_AAAA_5555, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_ADD, 8'h00, 8'h00, 8'h00,
                         64'h1234_5678_9ABC_DEF0, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_DEL, 8'hFF, 8'hFE, 8'h00, 64'h0, 8'h00), 0, none);
    // keys with the free device address
    add_row(make_request(krt_pkg::MODE_ADD, 8'h01, 8'hFF, 8'h05,
                         64'h5555_AAAA_5555_AAAA, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_GET, 8'h01, 8'hFF, 8'h05, 64'h0, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_GET, 8'hFF, 8'hFF, 8'hFF, 64'h0, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_SET, 8'hFF, 8'hFF, 8'hFF,
                         64'hCAFE_F00D_0000_FFFF, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_DEL, 8'hFF, 8'hFF, 8'h00, 64'h0, 8'h00), 0, none);
    add_row(make_request(krt_pkg::MODE_READ, 8'h00, 8'h00, 8'h00, 64'h0, 8'd1), 0, none);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].want);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 450 && n < 560);
      send_request(random_request(n), 0, none);
    end
    no_idle  = 1'b0;
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (krt_pkg::ENTRIES + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
